/* rtl/json_byte_tokenizer_assert.svh */
// assertion macros for the checker file of the json byte tokenizer
// no dependencies; the user provides clk_i and rst_ni in scope
`ifndef JSON_BYTE_TOKENIZER_ASSERT_SVH
`define JSON_BYTE_TOKENIZER_ASSERT_SVH

// same-cycle implication
`define JBT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define JBT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/jbt_pkg.sv */
// types, constants and byte-class helpers for the json byte tokenizer
// no dependencies
package jbt_pkg;

  localparam int unsigned POS_W   = 16;
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned QPTR_W  = $clog2(Q_DEPTH);
  localparam int unsigned QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_STRING,
    MODE_NUMBER,
    MODE_WORD
  } lex_mode_e;

  typedef enum logic [3:0] {
    KIND_STRING = 4'd0,
    KIND_NUMBER = 4'd1,
    KIND_NULL   = 4'd2,
    KIND_TRUE   = 4'd3,
    KIND_FALSE  = 4'd4,
    KIND_LBRACK = 4'd5,
    KIND_RBRACK = 4'd6,
    KIND_LBRACE = 4'd7,
    KIND_RBRACE = 4'd8,
    KIND_COLON  = 4'd9,
    KIND_COMMA  = 4'd10,
    KIND_ERROR  = 4'd11
  } tok_kind_e;

  // number phases
  localparam logic [2:0] PH_SIGN   = 3'd0;
  localparam logic [2:0] PH_INT    = 3'd1;
  localparam logic [2:0] PH_DOT    = 3'd2;
  localparam logic [2:0] PH_FRAC   = 3'd3;
  localparam logic [2:0] PH_EXP    = 3'd4;
  localparam logic [2:0] PH_ESIGN  = 3'd5;
  localparam logic [2:0] PH_EDIG   = 3'd6;
  localparam logic [2:0] PH_REJECT = 3'd7;

  // keyword match bits: 0 null, 1 true, 2 false
  localparam logic [2:0] KW_ALL = 3'b111;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  typedef struct packed {
    tok_kind_e   kind;
    logic [15:0] line;
    logic [15:0] start;
    logic [15:0] len;
    logic        last;
  } tok_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic [2:0] number_next(input logic [2:0] ph, input logic [7:0] b);
    logic d;
    logic e;
    logic [2:0] nx;
    d  = is_digit(b);
    e  = (b == "e") || (b == "E");
    nx = PH_REJECT;
    case (ph)
      PH_SIGN:  nx = d ? PH_INT : PH_REJECT;
      PH_INT:   nx = d ? PH_INT : (b == ".") ? PH_DOT : e ? PH_EXP : PH_REJECT;
      PH_DOT:   nx = d ? PH_FRAC : e ? PH_EXP : PH_REJECT;
      PH_FRAC:  nx = d ? PH_FRAC : e ? PH_EXP : PH_REJECT;
      PH_EXP:   nx = d ? PH_EDIG : ((b == "+") || (b == "-")) ? PH_ESIGN : PH_REJECT;
      PH_ESIGN: nx = d ? PH_EDIG : PH_REJECT;
      PH_EDIG:  nx = d ? PH_EDIG : PH_REJECT;
      default:  nx = PH_REJECT;
    endcase
    return nx;
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    return (k == 2'd2) ? 3'd5 : 3'd4;
  endfunction

  function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] idx);
    logic [7:0] c;
    c = 8'h00;
    case ({k, idx})
      {2'd0, 3'd0}: c = "n";
      {2'd0, 3'd1}: c = "u";
      {2'd0, 3'd2}: c = "l";
      {2'd0, 3'd3}: c = "l";
      {2'd1, 3'd0}: c = "t";
      {2'd1, 3'd1}: c = "r";
      {2'd1, 3'd2}: c = "u";
      {2'd1, 3'd3}: c = "e";
      {2'd2, 3'd0}: c = "f";
      {2'd2, 3'd1}: c = "a";
      {2'd2, 3'd2}: c = "l";
      {2'd2, 3'd3}: c = "s";
      {2'd2, 3'd4}: c = "e";
      default:      c = 8'h00;
    endcase
    return c;
  endfunction

  // drop keywords that byte b at offset run cannot continue
  function automatic logic [2:0] match_byte(input logic [2:0] km, input logic [15:0] run,
                                            input logic [7:0] b);
    logic [2:0] r;
    r = km;
    for (int k = 0; k < 3; k++) begin
      if ((run >= 16'(kw_len(2'(k)))) || (kw_char(2'(k), run[2:0]) != b)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  function automatic tok_kind_e flush_kind(input lex_mode_e mode, input logic [2:0] ph,
                                           input logic [2:0] km, input logic [15:0] run);
    tok_kind_e kd;
    kd = KIND_ERROR;
    case (mode)
      MODE_STRING: kd = KIND_STRING;
      MODE_NUMBER: kd = (ph inside {PH_INT, PH_DOT, PH_FRAC, PH_EDIG}) ? KIND_NUMBER
                                                                      : KIND_ERROR;
      MODE_WORD: begin
        if (km[0] && (run == 16'd4)) begin
          kd = KIND_NULL;
        end else if (km[1] && (run == 16'd4)) begin
          kd = KIND_TRUE;
        end else if (km[2] && (run == 16'd5)) begin
          kd = KIND_FALSE;
        end else begin
          kd = KIND_ERROR;
        end
      end
      default: kd = KIND_ERROR;
    endcase
    return kd;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] sat_start(input logic [POS_W-1:0] p);
    logic [31:0] w;
    w = 32'(p);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

endpackage

/* rtl/jbt_if.sv */
// handshake channels of the json byte tokenizer: text bytes in, tokens out
// no dependencies
interface jbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jbt_tok_if;
  logic        valid;
  logic        ready;
  logic [3:0]  token_kind;
  logic [15:0] line_number;
  logic [15:0] start_position;
  logic [15:0] token_length;
  logic        last_of_run;

  modport source (output valid, output token_kind, output line_number,
                  output start_position, output token_length, output last_of_run,
                  input ready);
  modport sink (input valid, input token_kind, input line_number,
                input start_position, input token_length, input last_of_run,
                output ready);
endinterface

/* rtl/json_byte_tokenizer.sv */
// tokens caused by a byte are registered into the token queue on its beat and reach the output from its head
// throughput: one byte per cycle; tokens average at most one per byte and the 4-entry
// queue absorbs a byte that yields two; input stalls only when more than two tokens wait
// reset: asynchronous, active low; idle, position 0, line 1, queue empty
// end of text flushes the pending token and returns the lexer state, but not the queue, to its reset values
// depends on jbt_pkg and jbt_if
module json_byte_tokenizer
  import jbt_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  jbt_in_if.sink        in_i,
  jbt_tok_if.source     out_o
);

  lex_mode_e         mode_q, mode_d;
  logic [2:0]        phase_q, phase_d;
  logic [2:0]        kmatch_q, kmatch_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [15:0]       line_q, line_d;
  logic [POS_W-1:0]  tstart_q, tstart_d;
  logic [15:0]       run_q, run_d;

  tok_t              queue_q [Q_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  tok_t              res0, res1;
  logic [1:0]        nres;
  logic              in_fire, out_fire;
  logic [7:0]        b;

  assign b        = in_i.text_byte;
  assign in_i.ready = (cnt_q <= QCNT_W'(Q_DEPTH - 2));
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;

  always_comb begin : next_state
    logic taken;
    logic [2:0] ph_nx;
    tok_t t;
    mode_d   = mode_q;
    phase_d  = phase_q;
    kmatch_d = kmatch_q;
    pos_d    = pos_q;
    line_d   = line_q;
    tstart_d = tstart_q;
    run_d    = run_q;
    res0     = '0;
    res1     = '0;
    nres     = 2'd0;
    taken    = 1'b0;
    ph_nx    = number_next(phase_q, b);
    t        = '0;

    if (in_fire) begin
      // continue or close the pending token
      case (mode_q)
        MODE_STRING: begin
          taken = 1'b1;
          if ((b == 8'h22) || (b == 8'h00)) begin
            res0   = '{kind: KIND_STRING, line: line_q, start: sat_start(tstart_q),
                       len: run_q, last: 1'b0};
            nres   = 2'd1;
            mode_d = MODE_IDLE;
          end else begin
            run_d = sat_inc16(run_q);
          end
        end
        MODE_NUMBER: begin
          if (ph_nx != PH_REJECT) begin
            taken   = 1'b1;
            phase_d = ph_nx;
            run_d   = sat_inc16(run_q);
          end else begin
            res0   = '{kind: flush_kind(mode_q, phase_q, kmatch_q, run_q), line: line_q,
                       start: sat_start(tstart_q), len: run_q, last: 1'b0};
            nres   = 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        MODE_WORD: begin
          if (is_letter(b) || is_digit(b)) begin
            taken    = 1'b1;
            kmatch_d = match_byte(kmatch_q, run_q, b);
            run_d    = sat_inc16(run_q);
          end else begin
            res0   = '{kind: flush_kind(mode_q, phase_q, kmatch_q, run_q), line: line_q,
                       start: sat_start(tstart_q), len: run_q, last: 1'b0};
            nres   = 2'd1;
            mode_d = MODE_IDLE;
          end
        end
        default: ;
      endcase

      // byte taken afresh
      if (!taken) begin
        tstart_d = pos_q;
        run_d    = 16'd0;
        t        = '{kind: KIND_ERROR, line: line_q, start: sat_start(pos_q),
                     len: 16'd1, last: 1'b0};
        if (b == 8'h22) begin
          mode_d = MODE_STRING;
        end else if (is_digit(b) || (b == "-")) begin
          mode_d  = MODE_NUMBER;
          phase_d = is_digit(b) ? PH_INT : PH_SIGN;
          run_d   = 16'd1;
        end else if (is_letter(b)) begin
          mode_d   = MODE_WORD;
          kmatch_d = match_byte(KW_ALL, 16'd0, b);
          run_d    = 16'd1;
        end else if (b == 8'h0A) begin
          line_d = sat_inc16(line_q);
        end else begin
          case (b)
            "[":     t.kind = KIND_LBRACK;
            "]":     t.kind = KIND_RBRACK;
            "{":     t.kind = KIND_LBRACE;
            "}":     t.kind = KIND_RBRACE;
            ":":     t.kind = KIND_COLON;
            ",":     t.kind = KIND_COMMA;
            default: t.kind = KIND_ERROR;
          endcase
          if (t.kind != KIND_ERROR) begin
            if (nres == 2'd0) begin
              res0 = t;
            end else begin
              res1 = t;
            end
            nres = nres + 2'd1;
          end
        end
      end

      if (pos_q != '1) begin
        pos_d = pos_q + POS_W'(1);
      end

      if (in_i.end_of_text) begin
        if (mode_d != MODE_IDLE) begin
          t = '{kind: flush_kind(mode_d, phase_d, kmatch_d, run_d), line: line_d,
                start: sat_start(tstart_d), len: run_d, last: 1'b0};
          if (nres == 2'd0) begin
            res0 = t;
          end else begin
            res1 = t;
          end
          nres = nres + 2'd1;
        end
        mode_d   = MODE_IDLE;
        phase_d  = PH_SIGN;
        kmatch_d = KW_ALL;
        pos_d    = '0;
        line_d   = 16'd1;
        tstart_d = '0;
        run_d    = 16'd0;
      end

      if (nres == 2'd1) begin
        res0.last = 1'b1;
      end else if (nres == 2'd2) begin
        res1.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      phase_q  <= PH_SIGN;
      kmatch_q <= KW_ALL;
      pos_q    <= '0;
      line_q   <= 16'd1;
      tstart_q <= '0;
      run_q    <= 16'd0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      phase_q  <= phase_d;
      kmatch_q <= kmatch_d;
      pos_q    <= pos_d;
      line_q   <= line_d;
      tstart_q <= tstart_d;
      run_q    <= run_d;
      wr_ptr_q <= wr_ptr_q + QPTR_W'(nres);
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      cnt_q <= cnt_q + QCNT_W'(nres) - QCNT_W'(out_fire);
    end
  end

  // token queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (nres == 2'd2) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= res1;
    end
  end

  assign out_o.valid          = (cnt_q != '0);
  assign out_o.token_kind     = queue_q[rd_ptr_q].kind;
  assign out_o.line_number    = queue_q[rd_ptr_q].line;
  assign out_o.start_position = queue_q[rd_ptr_q].start;
  assign out_o.token_length   = queue_q[rd_ptr_q].len;
  assign out_o.last_of_run    = queue_q[rd_ptr_q].last;

endmodule

/* rtl/jbt_checker.sv */
// port-level checks for the json byte tokenizer, attached by bind
// depends on jbt_pkg and json_byte_tokenizer_assert.svh
`include "json_byte_tokenizer_assert.svh"

module jbt_checker
  import jbt_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [3:0]  token_kind_i,
  input logic [15:0] line_number_i,
  input logic [15:0] token_length_i
);

  logic punct_beat;
  logic out_stall;

  assign punct_beat = out_valid_i && (token_kind_i >= KIND_LBRACK) &&
                      (token_kind_i <= KIND_COMMA);
  assign out_stall  = out_valid_i && !out_ready_i;

  `JBT_ASSERT_NOW(a_kind_range, out_valid_i, token_kind_i <= KIND_ERROR, "bad token kind")
  `JBT_ASSERT_NOW(a_line_nonzero, out_valid_i, line_number_i != 16'd0, "line number zero")
  `JBT_ASSERT_NOW(a_punct_len, punct_beat, token_length_i == 16'd1, "punctuation length not one")
  `JBT_ASSERT_NEXT(a_out_hold, out_stall, out_valid_i && $stable(token_kind_i), "beat not held")

endmodule

bind json_byte_tokenizer jbt_checker u_jbt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .line_number_i  (out_o.line_number),
  .token_length_i (out_o.token_length)
);
